// ----- rtl/pswi_pkg.sv -----
// Shared types, control word layout and microprogram for the speed-loop PID.
// No dependencies; used by pswi_seq, pswi_dp and the top level.
`default_nettype none
package pswi_pkg;

    localparam int PC_W     = 4;
    localparam int GAIN_W   = 8;
    localparam int ERR_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DRIVE_W  = 9;
    localparam int SHR_I    = 9;

    localparam logic [GAIN_W-1:0]    GAIN_RESET = 8'd25;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV  = 2'd2;

    localparam logic signed [31:0]        I_LIMIT   = 32'sh0080_0000;
    localparam logic signed [31:0]        CV_MAX    = 32'sd255;
    localparam logic signed [31:0]        CV_MIN    = -32'sd255;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 9'sd255;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -9'sd255;

    typedef enum logic [1:0] {MA_ERR, MA_DIFF, MA_WT, MA_T} t_mul_a;
    typedef enum logic [1:0] {MB_KP, MB_KI, MB_KD} t_mul_b;
    typedef enum logic [1:0] {DST_NONE, DST_ACC_LOAD, DST_ACC_ADD, DST_T_LOAD} t_dest;
    typedef enum logic [2:0] {CND_NEVER, CND_ALWAYS, CND_NO_ACCEPT, CND_T_BIG,
                              CND_OUT_BUSY} t_cond;

    typedef struct packed {
        logic              idle;
        t_mul_a            mul_a;
        t_mul_b            mul_b;
        t_dest             dest;
        logic              win_upd;
        logic              shr_t;
        logic              add_t;
        logic              finish;
        logic              last;
        t_cond             cond;
        logic [PC_W-1:0]   target;
    } t_cword;

    typedef struct packed {
        logic accept;
        logic t_big;
        logic out_busy;
    } t_stat;

    localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] PC_SHR_B = 4'd7;
    localparam logic [PC_W-1:0] PC_ADD_I = 4'd9;
    localparam logic [PC_W-1:0] PC_FIN   = 4'd10;

    function automatic t_cword cw(logic idle, t_mul_a ma, t_mul_b mb, t_dest dst,
                                  logic wu, logic st, logic at, logic fin,
                                  logic lst, t_cond c, logic [PC_W-1:0] tgt);
        t_cword w;
        w.idle = idle; w.mul_a = ma; w.mul_b = mb; w.dest = dst;
        w.win_upd = wu; w.shr_t = st; w.add_t = at; w.finish = fin;
        w.last = lst; w.cond = c; w.target = tgt;
        return w;
    endfunction

    // microprogram: P, D, window update, I with the 2^23 branch, sum, drive
    function automatic t_cword ucode(logic [PC_W-1:0] pc);
        t_cword w;
        case (pc)
            4'd0:  w = cw(1'b1, MA_ERR,  MB_KP, DST_NONE,     1'b0, 1'b0, 1'b0, 1'b0,
                          1'b0, CND_NO_ACCEPT, PC_WAIT);
            4'd1:  w = cw(1'b0, MA_ERR,  MB_KP, DST_ACC_LOAD, 1'b0, 1'b0, 1'b0, 1'b0,
                          1'b0, CND_NEVER, PC_WAIT);
            4'd2:  w = cw(1'b0, MA_DIFF, MB_KD, DST_ACC_ADD,  1'b1, 1'b0, 1'b0, 1'b0,
                          1'b0, CND_NEVER, PC_WAIT);
            4'd3:  w = cw(1'b0, MA_WT,   MB_KI, DST_T_LOAD,   1'b0, 1'b0, 1'b0, 1'b0,
                          1'b0, CND_NEVER, PC_WAIT);
            4'd4:  w = cw(1'b0, MA_T,    MB_KP, DST_NONE,     1'b0, 1'b0, 1'b0, 1'b0,
                          1'b0, CND_T_BIG, PC_SHR_B);
            4'd5:  w = cw(1'b0, MA_T,    MB_KP, DST_T_LOAD,   1'b0, 1'b0, 1'b0, 1'b0,
                          1'b0, CND_NEVER, PC_WAIT);
            4'd6:  w = cw(1'b0, MA_T,    MB_KP, DST_NONE,     1'b0, 1'b1, 1'b0, 1'b0,
                          1'b0, CND_ALWAYS, PC_ADD_I);
            4'd7:  w = cw(1'b0, MA_T,    MB_KP, DST_NONE,     1'b0, 1'b1, 1'b0, 1'b0,
                          1'b0, CND_NEVER, PC_WAIT);
            4'd8:  w = cw(1'b0, MA_T,    MB_KP, DST_T_LOAD,   1'b0, 1'b0, 1'b0, 1'b0,
                          1'b0, CND_NEVER, PC_WAIT);
            4'd9:  w = cw(1'b0, MA_T,    MB_KP, DST_NONE,     1'b0, 1'b0, 1'b1, 1'b0,
                          1'b0, CND_NEVER, PC_WAIT);
            4'd10: w = cw(1'b0, MA_T,    MB_KP, DST_NONE,     1'b0, 1'b0, 1'b0, 1'b1,
                          1'b1, CND_OUT_BUSY, PC_FIN);
            default: w = cw(1'b0, MA_T,  MB_KP, DST_NONE,     1'b0, 1'b0, 1'b0, 1'b0,
                          1'b0, CND_ALWAYS, PC_WAIT);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pswi_seq.sv -----
// Microcode sequencer: step counter, program table fetch and conditional jumps.
// Depends on pswi_pkg.
`default_nettype none
module pswi_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pswi_pkg::t_stat i_stat,
    output pswi_pkg::t_cword     o_cw
);

    logic [pswi_pkg::PC_W-1:0] r_pc, n_pc;
    pswi_pkg::t_cword          w;
    logic                      take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= pswi_pkg::PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        w = pswi_pkg::ucode(r_pc);
        case (w.cond)
            pswi_pkg::CND_NEVER:     take = 1'b0;
            pswi_pkg::CND_ALWAYS:    take = 1'b1;
            pswi_pkg::CND_NO_ACCEPT: take = !i_stat.accept;
            pswi_pkg::CND_T_BIG:     take = i_stat.t_big;
            pswi_pkg::CND_OUT_BUSY:  take = i_stat.out_busy;
            default:                 take = 1'b1;
        endcase
        if (take) begin
            n_pc = w.target;
        end else if (w.last) begin
            n_pc = pswi_pkg::PC_WAIT;
        end else begin
            n_pc = r_pc + 1'b1;
        end
        o_cw = w;
    end

endmodule
`default_nettype wire

// ----- rtl/pswi_dp.sv -----
// Datapath: error history memory with clearing pass, shared multiplier,
// accumulators, clamp, drive stage and output register. Depends on pswi_pkg.
`default_nettype none
module pswi_dp #(
    parameter int HISTORY_DEPTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire pswi_pkg::t_cword            i_cw,
    input  wire logic                        i_accept,
    input  wire logic signed [15:0]          i_target_speed,
    input  wire logic signed [15:0]          i_measured_speed,
    input  wire logic [pswi_pkg::GAIN_W-1:0] i_kp,
    input  wire logic [pswi_pkg::GAIN_W-1:0] i_ki,
    input  wire logic [pswi_pkg::GAIN_W-1:0] i_kd,
    input  wire logic                        i_out_stall,
    output pswi_pkg::t_stat                  o_stat,
    output logic                             o_clearing,
    output logic                             o_out_valid,
    output logic [7:0]                       o_duty,
    output logic                             o_direction,
    output logic signed [8:0]                o_drive_value
);

    localparam int AW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int WTW = 17 + AW;
    localparam logic [AW-1:0] PTR_LAST = AW'(HISTORY_DEPTH - 1);

    logic [pswi_pkg::ERR_W-1:0] mem [HISTORY_DEPTH];
    logic [pswi_pkg::ERR_W-1:0] r_rd;
    logic                       mem_we;
    logic [pswi_pkg::ERR_W-1:0] mem_wd;

    logic                       r_clearing;
    logic [AW-1:0]              r_ptr;
    logic [WTW-1:0]             r_wt;
    logic [pswi_pkg::ERR_W-1:0] r_err, r_prev;
    logic [31:0]                r_acc, r_t;
    logic                       r_dir;
    logic [7:0]                 r_duty;
    logic                       r_out_valid;
    logic [7:0]                 r_o_duty;
    logic                       r_o_dir;
    logic signed [8:0]          r_o_drive;

    logic signed [31:0]         mul_a;
    logic signed [8:0]          mul_b;
    logic signed [40:0]         prod_full;
    logic [31:0]                prod;
    logic signed [31:0]         err_x, prev_x, total;
    logic signed [8:0]          cv;
    logic                       want;
    logic [8:0]                 cv_neg;
    logic                       out_busy;

    assign err_x  = 32'(signed'(r_err));
    assign prev_x = 32'(signed'(r_prev));

    always_comb begin
        case (i_cw.mul_a)
            pswi_pkg::MA_ERR:  mul_a = err_x;
            pswi_pkg::MA_DIFF: mul_a = err_x - prev_x;
            pswi_pkg::MA_WT:   mul_a = 32'(signed'(r_wt));
            pswi_pkg::MA_T:    mul_a = r_t;
            default:           mul_a = r_t;
        endcase
        case (i_cw.mul_b)
            pswi_pkg::MB_KP: mul_b = signed'({1'b0, i_kp});
            pswi_pkg::MB_KI: mul_b = signed'({1'b0, i_ki});
            pswi_pkg::MB_KD: mul_b = signed'({1'b0, i_kd});
            default:         mul_b = signed'({1'b0, i_kp});
        endcase
        prod_full = mul_a * mul_b;
        prod      = prod_full[31:0];
    end

    // control value and drive decision
    always_comb begin
        total = signed'(r_acc) >>> 1;
        if (total > pswi_pkg::CV_MAX) begin
            cv = pswi_pkg::DRIVE_MAX;
        end else if (total < pswi_pkg::CV_MIN) begin
            cv = pswi_pkg::DRIVE_MIN;
        end else begin
            cv = total[8:0];
        end
        want   = !cv[8] && (cv != 9'sd0);
        cv_neg = 9'(-cv);
    end

    assign out_busy = r_out_valid && i_out_stall;

    assign mem_we = r_clearing || i_cw.win_upd;
    assign mem_wd = r_clearing ? '0 : r_err;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_ptr] <= mem_wd;
        end
        r_rd <= mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_ptr       <= '0;
            r_wt        <= '0;
            r_prev      <= '0;
            r_dir       <= 1'b0;
            r_duty      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_ptr <= (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
                if (r_ptr == PTR_LAST) begin
                    r_clearing <= 1'b0;
                end
            end else if (i_cw.win_upd) begin
                r_ptr  <= (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
                r_wt   <= r_wt - WTW'(signed'(r_rd)) + WTW'(signed'(r_err));
                r_prev <= r_err;
            end
            if (i_cw.finish && !out_busy) begin
                r_out_valid <= 1'b1;
                if (want != r_dir) begin
                    if (r_duty != 8'd0) begin
                        r_duty <= '0;
                    end else begin
                        r_dir <= want;
                    end
                end else begin
                    r_duty <= cv[8] ? cv_neg[7:0] : cv[7:0];
                end
            end else if (!out_busy) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_err <= 16'(i_target_speed - i_measured_speed);
        end
        case (i_cw.dest)
            pswi_pkg::DST_ACC_LOAD: r_acc <= prod;
            pswi_pkg::DST_ACC_ADD:  r_acc <= r_acc + prod;
            pswi_pkg::DST_T_LOAD:   r_t   <= prod;
            default: ;
        endcase
        if (i_cw.shr_t) begin
            r_t <= 32'(signed'(r_t) >>> pswi_pkg::SHR_I);
        end
        if (i_cw.add_t) begin
            r_acc <= r_acc + r_t;
        end
        if (i_cw.finish && !out_busy) begin
            r_o_drive <= cv;
            if (want != r_dir) begin
                r_o_duty <= '0;
                r_o_dir  <= (r_duty != 8'd0) ? r_dir : want;
            end else begin
                r_o_duty <= cv[8] ? cv_neg[7:0] : cv[7:0];
                r_o_dir  <= r_dir;
            end
        end
    end

    assign o_stat.accept   = i_accept;
    assign o_stat.t_big    = !(signed'(r_t) < pswi_pkg::I_LIMIT);
    assign o_stat.out_busy = out_busy;
    assign o_clearing      = r_clearing;
    assign o_out_valid     = r_out_valid;
    assign o_duty          = r_o_duty;
    assign o_direction     = r_o_dir;
    assign o_drive_value   = r_o_drive;

endmodule
`default_nettype wire

// ----- rtl/pid_speed_loop_windowed_integral.sv -----
// Speed-loop PID with moving-window integral: each item runs through the
// microprogram steps on one shared 32x9 multiplier, and a new item is taken
// only after the last result is registered, which waits while the output is held.
// After reset the error history is cleared entry by entry, during which
// no item is taken; gains reset to 25. Depends on pswi_pkg, pswi_seq, pswi_dp.
`default_nettype none
module pid_speed_loop_windowed_integral #(
    parameter int HISTORY_DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pswi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [pswi_pkg::GAIN_W-1:0]    i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [15:0]             i_target_speed,
    input  wire logic signed [15:0]             i_measured_speed,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [7:0]                          o_duty,
    output logic                                o_direction,
    output logic signed [8:0]                   o_drive_value
);

    logic [pswi_pkg::GAIN_W-1:0] r_kp, r_ki, r_kd;
    pswi_pkg::t_cword            cw;
    pswi_pkg::t_stat             stat;
    logic                        clearing;
    logic                        accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= pswi_pkg::GAIN_RESET;
            r_ki <= pswi_pkg::GAIN_RESET;
            r_kd <= pswi_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pswi_pkg::CFG_PROP:  r_kp <= i_cfg_data;
                pswi_pkg::CFG_INTEG: r_ki <= i_cfg_data;
                pswi_pkg::CFG_DERIV: r_kd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = !(cw.idle && !clearing);
    assign accept     = i_in_valid && !o_in_stall;

    pswi_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cw    (cw)
    );

    pswi_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cw             (cw),
        .i_accept         (accept),
        .i_target_speed   (i_target_speed),
        .i_measured_speed (i_measured_speed),
        .i_kp             (r_kp),
        .i_ki             (r_ki),
        .i_kd             (r_kd),
        .i_out_stall      (i_out_stall),
        .o_stat           (stat),
        .o_clearing       (clearing),
        .o_out_valid      (o_out_valid),
        .o_duty           (o_duty),
        .o_direction      (o_direction),
        .o_drive_value    (o_drive_value)
    );

endmodule
`default_nettype wire
